/* sv/urlpd_pkg.sv */
// Package for the URL path decoder and checker.
// Holds transaction types, character constants, the escape phase codes and
// the hex digit helper. No dependencies.
package urlpd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [1:0] DOTDOT_LEN = 2'd2;
  localparam logic [1:0] SEG_SAT    = 2'd3;
  localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] decoded_byte;
    logic       path_done;
    logic       path_ok;
  } out_t;

  typedef struct packed {
    esc_e       escape_phase;
    logic [3:0] high_nibble;
    logic       first_seen;
    logic       in_query;
    logic       rejected;
    logic [1:0] segment_length;
    logic       segment_all_dots;
  } state_t;

  localparam state_t STATE_RESET = '{
    escape_phase:     ESC_NONE,
    high_nibble:      4'd0,
    first_seen:       1'b0,
    in_query:         1'b0,
    rejected:         1'b0,
    segment_length:   2'd0,
    segment_all_dots: 1'b1
  };

  // Return {digit_ok, nibble}; digit_ok low for anything but 0-9, a-f, A-F.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61) + HEX_ALPHA_BASE};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41) + HEX_ALPHA_BASE};
    end
    return r;
  endfunction

endpackage

/* sv/urlpd_step.sv */
// Next-state and result logic for one raw path byte.
// Purely combinational; depends on urlpd_pkg.
module urlpd_step import urlpd_pkg::*; (
  input  state_t cur_i,
  input  in_t    in_i,
  output state_t nxt_o,
  output out_t   res_o
);

  logic [7:0] b;
  logic [4:0] hx;
  logic [7:0] tk;
  logic       do_take;
  logic       cur_dotdot;
  logic       nxt_dotdot;
  state_t     nxt;
  out_t       res;

  assign b          = in_i.path_byte;
  assign hx         = hex_digit(b);
  assign cur_dotdot = (cur_i.segment_length == DOTDOT_LEN) && cur_i.segment_all_dots;

  always_comb begin
    nxt     = cur_i;
    res     = '0;
    do_take = 1'b0;
    tk      = b;
    if (!cur_i.in_query) begin
      if (b == CH_QUERY) begin
        nxt.in_query = 1'b1;
        if (!cur_i.first_seen || cur_i.escape_phase != ESC_NONE || cur_dotdot) begin
          nxt.rejected = 1'b1;
        end
      end else if (!cur_i.rejected) begin
        nxt.first_seen = 1'b1;
        if ((!cur_i.first_seen && b != CH_SLASH) || b == CH_NUL || b == CH_BSLASH) begin
          nxt.rejected = 1'b1;
        end else begin
          unique case (cur_i.escape_phase)
            ESC_HIGH: begin
              if (!hx[4]) begin
                nxt.rejected = 1'b1;
              end else begin
                nxt.high_nibble  = hx[3:0];
                nxt.escape_phase = ESC_LOW;
              end
            end
            ESC_LOW: begin
              nxt.escape_phase = ESC_NONE;
              if (!hx[4]) begin
                nxt.rejected = 1'b1;
              end else begin
                tk      = {cur_i.high_nibble, hx[3:0]};
                do_take = 1'b1;
              end
            end
            default: begin
              if (b == CH_PERCENT) begin
                nxt.escape_phase = ESC_HIGH;
              end else begin
                nxt.escape_phase = ESC_NONE;
                do_take          = 1'b1;
              end
            end
          endcase
        end
      end
    end

    // Decoded byte: reject NUL and backslash, split on slash, track dots.
    if (do_take) begin
      if (tk == CH_NUL || tk == CH_BSLASH) begin
        nxt.rejected = 1'b1;
      end else if (tk == CH_SLASH) begin
        if (cur_dotdot) begin
          nxt.rejected = 1'b1;
        end else begin
          nxt.segment_length   = 2'd0;
          nxt.segment_all_dots = 1'b1;
          res.byte_valid       = 1'b1;
          res.decoded_byte     = tk;
        end
      end else begin
        if (cur_i.segment_length != SEG_SAT) begin
          nxt.segment_length = cur_i.segment_length + 2'd1;
        end
        if (tk != CH_DOT) begin
          nxt.segment_all_dots = 1'b0;
        end
        res.byte_valid   = 1'b1;
        res.decoded_byte = tk;
      end
    end

    // Close the path on the final byte unless a '?' already did.
    nxt_dotdot = (nxt.segment_length == DOTDOT_LEN) && nxt.segment_all_dots;
    if (in_i.last_byte) begin
      res.path_done = 1'b1;
      res.path_ok   = !(nxt.rejected || (!nxt.in_query &&
                      (!nxt.first_seen || nxt.escape_phase != ESC_NONE || nxt_dotdot)));
      nxt = STATE_RESET;
    end
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule

/* sv/url_path_decode_and_check_top.sv */
// Top level of the URL path percent-decoder and safety checker.
// Depends on urlpd_pkg and urlpd_step.
//
// Usage:
//   Raw request path bytes enter on the input channel, one transaction per
//   byte; last_byte marks the final byte of a path. Every input transaction
//   yields exactly one output transaction carrying an optional decoded byte
//   (byte_valid), and on the final byte path_done with the verdict path_ok.
//   The first raw '?' ends the path; later bytes give empty results.
//   Output valid rises in the cycle after the input byte is accepted.
//   Throughput: one byte per cycle unless the receiver stalls. The decode
//   state (escape phase, segment tracking, verdict) updates combinationally
//   in urlpd_step; the result register can load anew every unstalled cycle.
//   Stall: in_stall_o rises only when the result register is full and the
//   receiver stalls it; the held result stays unchanged until taken, and a
//   new byte is accepted in the same cycle the held result leaves.
//   Reset: asynchronous, active low; clears the decode state to the start
//   of a path and empties the result register.
//   After each final byte the decode state returns to its reset values.
module url_path_decode_and_check_top import urlpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_t state_q, state_d;
  out_t   res_q, res_d;
  logic   out_valid_q;
  logic   in_take;

  // Hold the input only while a finished result is stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  urlpd_step u_step (
    .cur_i (state_q),
    .in_i  (in_data_i),
    .nxt_o (state_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        state_q <= state_d;
      end
      // Advance when the register is free or its transaction leaves.
      if (!in_stall_o) begin
        out_valid_q <= in_take;
      end
    end
  end

  // Payload register: load on each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

/* sv/urlpd_checker.sv */
// Port-level checker for the URL path decoder, bound to the top level.
// Depends on urlpd_pkg.
module urlpd_checker import urlpd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // A decoded byte is never NUL or backslash; those reject instead.
  a_no_bad_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |->
      out_data_o.decoded_byte != CH_NUL && out_data_o.decoded_byte != CH_BSLASH)
    else $error("decoded NUL or backslash emitted");

  // A verdict appears only at the end of a path.
  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.path_ok |-> out_data_o.path_done)
    else $error("path_ok without path_done");

  // Input stall only comes from a full, stalled result register.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // An accepted byte yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted byte gave no result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind url_path_decode_and_check_top urlpd_checker u_urlpd_checker (.*);

/* bench/url_path_decode_and_check_top_tb.sv */
// Self-checking bench for url_path_decode_and_check_top: drives raw path bytes,
// predicts every decoded byte and verdict, and compares them in arrival order.
// Depends on urlpd_pkg and the RTL under sv/.
`timescale 1ns / 100ps

module url_path_decode_and_check_top_tb;
  import urlpd_pkg::*;

  typedef logic [7:0] path_q_t[$];

  localparam int QUIET_LIMIT = 1000;
  localparam string SEG_CHARS = "abcxyzABZ019-_.~";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  url_path_decode_and_check_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   mismatch_count = 0;
  int   quiet_cycles = 0;
  out_t decoded_results[$];
  out_t want;
  out_t got;

  // Mirror of the decoder state, one path at a time.
  esc_e       esc_phase;
  logic [3:0] hi_nibble;
  bit         seen_first;
  bit         past_query;
  bit         path_bad;
  logic [1:0] seg_len;
  bit         seg_dots;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void restart_path();
    esc_phase  = ESC_NONE;
    hi_nibble  = '0;
    seen_first = 1'b0;
    past_query = 1'b0;
    path_bad   = 1'b0;
    seg_len    = '0;
    seg_dots   = 1'b1;
  endfunction

  // {valid digit, value}; letters keep their low nibble offset by nine.
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic bit segment_is_dotdot();
    return seg_len == DOTDOT_LEN && seg_dots;
  endfunction

  // Apply one decoded character; return 1 when it goes out.
  function automatic bit take_char(logic [7:0] d);
    if (d == CH_NUL || d == CH_BSLASH) begin
      path_bad = 1'b1;
      return 1'b0;
    end
    if (d == CH_SLASH) begin
      if (segment_is_dotdot()) begin
        path_bad = 1'b1;
        return 1'b0;
      end
      seg_len  = '0;
      seg_dots = 1'b1;
      return 1'b1;
    end
    if (seg_len != SEG_SAT) seg_len = seg_len + 2'd1;
    if (d != CH_DOT) seg_dots = 1'b0;
    return 1'b1;
  endfunction

  function automatic void close_path();
    if (!seen_first || esc_phase != ESC_NONE || segment_is_dotdot()) path_bad = 1'b1;
  endfunction

  function automatic out_t decode_path_byte(in_t item);
    out_t       r;
    logic [4:0] h;
    logic [7:0] b;
    logic [7:0] d;
    r = '0;
    b = item.path_byte;
    if (!past_query) begin
      if (b == CH_QUERY) begin
        past_query = 1'b1;
        close_path();
      end else if (!path_bad) begin
        if (!seen_first) begin
          seen_first = 1'b1;
          if (b != CH_SLASH) path_bad = 1'b1;
        end
        if (b == CH_NUL || b == CH_BSLASH) path_bad = 1'b1;
        if (!path_bad) begin
          h = hex_nibble(b);
          case (esc_phase)
            ESC_HIGH: begin
              if (h[4]) begin
                hi_nibble = h[3:0];
                esc_phase = ESC_LOW;
              end else begin
                path_bad = 1'b1;
              end
            end
            ESC_LOW: begin
              esc_phase = ESC_NONE;
              d = {hi_nibble, h[3:0]};
              if (!h[4]) begin
                path_bad = 1'b1;
              end else if (take_char(d)) begin
                r.byte_valid   = 1'b1;
                r.decoded_byte = d;
              end
            end
            default: begin
              if (b == CH_PERCENT) begin
                esc_phase = ESC_HIGH;
              end else if (take_char(b)) begin
                r.byte_valid   = 1'b1;
                r.decoded_byte = b;
              end
            end
          endcase
        end
      end
    end
    if (item.last_byte) begin
      if (!past_query) close_path();
      r.path_done = 1'b1;
      r.path_ok   = !path_bad;
      restart_path();
    end
    return r;
  endfunction

  // Receiver: stall at random, changing at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each result taken with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = out_data_o;
      if (decoded_results.size() == 0) begin
        $error("result with nothing predicted: %h", got);
        mismatch_count++;
      end else begin
        want = decoded_results.pop_front();
        if (got.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
          mismatch_count++;
        end
        if (got.decoded_byte !== want.decoded_byte) begin
          $error("decoded_byte: expected %h, got %h", want.decoded_byte, got.decoded_byte);
          mismatch_count++;
        end
        if (got.path_done !== want.path_done) begin
          $error("path_done: expected %0d, got %0d", want.path_done, got.path_done);
          mismatch_count++;
        end
        if (got.path_ok !== want.path_ok) begin
          $error("path_ok: expected %0d, got %0d", want.path_ok, got.path_ok);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Starts and ends at a falling edge; valid stays high into the next byte.
  task automatic send_byte(logic [7:0] b, bit last);
    in_t item;
    item.path_byte = b;
    item.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decoded_results = {decoded_results, decode_path_byte(item)};
    @(negedge clk_i);
  endtask

  task automatic send_path(path_q_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  function automatic path_q_t text(string s);
    path_q_t p;
    for (int i = 0; i < s.len(); i++) p = {p, 8'(s[i])};
    return p;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void push_escape(ref path_q_t p, input logic [7:0] v);
    p = {p, CH_PERCENT, hex_char(v[7:4], 1'($urandom_range(1))),
         hex_char(v[3:0], 1'($urandom_range(1)))};
  endfunction

  // Hold input low until every predicted result has been taken.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (decoded_results.size() != 0) @(negedge clk_i);
  endtask

  // Extremes of the byte, both verdicts, escape forms and reject paths.
  task automatic test_directed_cases();
    string   cases[] = '{"/", "?", "a", "/%41%2f%2E%2e", "/../x", "/a%5c", "/%00",
                         "/\\abc", "/%4", "/%4?\\", "/%G0", "/%4g", "/b?%/", "/...",
                         "/..", "?/"};
    path_q_t p;
    foreach (cases[i]) send_path(text(cases[i]));
    p = {CH_SLASH, CH_NUL, CH_DOT};
    send_path(p);
    p = {CH_SLASH, 8'hFF, 8'h7F, 8'h80};
    send_path(p);
  endtask

  // Paths that start with '/', built from plain, dotted and escaped segments.
  task automatic test_wellformed_paths(int budget);
    path_q_t p;
    int      used;
    int      nseg;
    int      n;
    int      s;
    int      k;
    used = 0;
    while (used < budget) begin
      p = {CH_SLASH};
      nseg = $urandom_range(0, 4);
      for (s = 0; s < nseg; s++) begin
        if (s != 0) begin
          if ($urandom_range(4) == 0) push_escape(p, CH_SLASH);
          else p = {p, CH_SLASH};
        end
        case ($urandom_range(9))
          0, 1: begin
            repeat (2) begin
              if ($urandom_range(2) == 0) push_escape(p, CH_DOT);
              else p = {p, CH_DOT};
            end
          end
          2: p = {p, CH_DOT};
          3: p = {p, CH_DOT, CH_DOT, CH_DOT};
          default: begin
            n = $urandom_range(1, 5);
            repeat (n) begin
              if ($urandom_range(4) == 0) push_escape(p, 8'($urandom_range(255)));
              else p = {p, 8'(SEG_CHARS[$urandom_range(SEG_CHARS.len() - 1)])};
            end
          end
        endcase
      end
      if ($urandom_range(5) == 0) p = {p, CH_SLASH};
      used += p.size();
      // Tail after '?' is ignored by the block; keep it short.
      if ($urandom_range(3) == 0) begin
        p = {p, CH_QUERY};
        k = $urandom_range(0, 3);
        repeat (k) p = {p, 8'($urandom_range(255))};
      end
      send_path(p);
    end
  endtask

  // Short noisy paths rich in escape starts, dots, NUL, backslash and '?'.
  task automatic test_malformed_paths(int budget);
    logic [7:0] nasty[] = '{CH_PERCENT, CH_SLASH, CH_DOT, CH_QUERY, CH_BSLASH, CH_NUL,
                            8'h61, 8'h47, 8'h34};
    path_q_t    p;
    int         used;
    int         n;
    used = 0;
    while (used < budget) begin
      p = {};
      if ($urandom_range(1) == 0) p = {p, CH_SLASH};
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(2) == 0) p = {p, 8'($urandom_range(255))};
        else p = {p, nasty[$urandom_range(nasty.size() - 1)]};
      end
      used += p.size();
      send_path(p);
    end
  endtask

  initial begin
    restart_path();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Light sender gaps, heavy receiver stalls.
    send_idle_pct = 13;
    recv_idle_pct = 51;
    test_directed_cases();
    test_wellformed_paths(100);
    test_malformed_paths(40);
    wait_for_drain();

    // Heavy sender gaps, light receiver stalls.
    send_idle_pct = 51;
    recv_idle_pct = 13;
    test_wellformed_paths(100);
    test_malformed_paths(40);
    wait_for_drain();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_wellformed_paths(100);
    test_malformed_paths(40);

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (decoded_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
